// ----- src/epr_pkg.sv -----
// Shared types and constants for the emulation prevention byte remover.
// No dependencies.
`default_nettype none
package epr_pkg;

	localparam logic [7:0] PREVENTION_BYTE = 8'h03;
	localparam logic [7:0] NUL_BYTE        = 8'h00;
	localparam logic [1:0] ZERO_LIMIT      = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FORBIDDEN = 2'd1,
		ST_BAD_EPB   = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       unit_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       byte_valid;
		logic       unit_end;
		status_t    status;
	} out_beat_t;

	typedef struct packed {
		logic       at_header;
		logic [1:0] zero_run;
		logic       after_prevention;
		logic       unit_failed;
	} unit_state_t;

endpackage
`default_nettype wire

// ----- src/emulation_prevention_remover_top.sv -----
// Emulation prevention byte remover: NAL unit bytes in, RBSP bytes out.
// Path: from input beat accept through the input reg, then the result reg, to result beat accept.
// Throughput: one byte per cycle while out_ready is high; one result beat per input beat.
// The unit state advances as a byte moves from the input reg to the result reg.
// Reset (arst_n low, async): both regs empty, next byte treated as a header.
// Depends on epr_pkg and epr_core.
`default_nettype none
module emulation_prevention_remover_top import epr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_beat_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_beat_t      out_data
);

	logic      valid_s1;
	in_beat_t  beat_s1;
	logic      valid_s2;
	out_beat_t beat_s2;
	out_beat_t result;
	logic      s2_free;
	logic      advance;

	assign s2_free  = ~valid_s2 | out_ready;
	assign advance  = valid_s1 & s2_free;
	assign in_ready = ~valid_s1 | s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			beat_s1 <= in_data;
	end

	epr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			beat_s2 <= result;
	end

	assign out_valid = valid_s2;
	assign out_data  = beat_s2;

	a_ok_when_passed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_valid |-> out_data.status == ST_OK)
		else $error("passed byte carries error status");

	a_zero_when_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |-> out_data.payload_byte == NUL_BYTE)
		else $error("dropped byte has nonzero payload");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(beat_s1))
		else $error("input reg lost a beat");

endmodule
`default_nettype wire

// ----- src/epr_core.sv -----
// Per-byte decode and unit state for emulation prevention removal.
// Depends on epr_pkg.
`default_nettype none
module epr_core import epr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_beat_t  beat,
	output out_beat_t      result
);

	localparam unit_state_t UNIT_CLEAR = '{at_header: 1'b1, zero_run: 2'd0,
		after_prevention: 1'b0, unit_failed: 1'b0};

	unit_state_t state_q;
	unit_state_t state_d;
	unit_state_t state_upd;

	always_comb begin
		logic [7:0] b;
		b = beat.data_byte;
		state_upd = state_q;
		result.payload_byte = NUL_BYTE;
		result.byte_valid   = 1'b0;
		result.unit_end     = beat.unit_last;
		result.status       = ST_OK;
		if (state_q.at_header) begin
			result.payload_byte = b;
			result.byte_valid   = 1'b1;
			state_upd.at_header = 1'b0;
		end else if (state_q.unit_failed) begin
			state_upd = state_q;
		end else if (state_q.after_prevention) begin
			state_upd.after_prevention = 1'b0;
			if (b > PREVENTION_BYTE) begin
				result.status         = ST_BAD_EPB;
				state_upd.unit_failed = 1'b1;
			end else begin
				result.payload_byte = b;
				result.byte_valid   = 1'b1;
				state_upd.zero_run  = (b == NUL_BYTE) ? 2'd1 : 2'd0;
			end
		end else if (state_q.zero_run == ZERO_LIMIT && b < PREVENTION_BYTE) begin
			result.status         = ST_FORBIDDEN;
			state_upd.unit_failed = 1'b1;
		end else if (state_q.zero_run == ZERO_LIMIT && b == PREVENTION_BYTE) begin
			state_upd.zero_run         = 2'd0;
			state_upd.after_prevention = ~beat.unit_last;
		end else begin
			result.payload_byte = b;
			result.byte_valid   = 1'b1;
			if (b == NUL_BYTE) begin
				if (state_q.zero_run < ZERO_LIMIT)
					state_upd.zero_run = state_q.zero_run + 2'd1;
			end else begin
				state_upd.zero_run = 2'd0;
			end
		end
		state_d = beat.unit_last ? UNIT_CLEAR : state_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= UNIT_CLEAR;
		end else if (step) begin
			state_q <= state_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && beat.unit_last |=> state_q.at_header && !state_q.unit_failed)
		else $error("unit state not cleared after last byte");

	a_suppressed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.unit_failed && !state_q.at_header |->
		!result.byte_valid && result.status == ST_OK)
		else $error("byte passed or error repeated after failure");

	a_zero_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.zero_run != 2'd3)
		else $error("zero run beyond limit");

	a_epb_no_fail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.after_prevention |-> !state_q.unit_failed && state_q.zero_run == 2'd0)
		else $error("inconsistent state after prevention byte");

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for emulation_prevention_remover_top: NAL unit bytes in, RBSP beats out.
// A directed table is run first, then random units, under several idle and stall patterns.
// Depends on epr_pkg and the emulation_prevention_remover_top RTL.
`default_nettype none
module testbench;
	import epr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BEATS = 80;
	localparam int HOLD_CYCLES = 250;
	localparam int DIR_ROWS    = 25;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		in_beat_t  beat;
		logic      given;
		out_beat_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	emulation_prevention_remover_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	out_beat_t   rbsp_expected[$];
	unit_state_t nal_state;
	idle_mode_t  idle_mode;
	bit          hold_req;
	int          mismatches = 0;
	int          beats_sent;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h03, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h03, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h03, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h04, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, ST_BAD_EPB}},
		'{'{8'hAA, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h55, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}},
		'{'{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, ST_OK}},
		'{'{8'h65, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h01, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0, ST_FORBIDDEN}},
		'{'{8'h02, 1'b1}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h41, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h03, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}},
		'{'{8'h80, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
		'{'{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, ST_FORBIDDEN}}
	};

	function automatic out_beat_t strip_epb(input in_beat_t b);
		out_beat_t r;
		r = '{8'h00, 1'b0, b.unit_last, ST_OK};
		if (nal_state.at_header) begin
			r.payload_byte = b.data_byte;
			r.byte_valid = 1'b1;
			nal_state.at_header = 1'b0;
		end else if (nal_state.unit_failed) begin
			r.byte_valid = 1'b0;
		end else if (nal_state.after_prevention) begin
			nal_state.after_prevention = 1'b0;
			if (b.data_byte > PREVENTION_BYTE) begin
				r.status = ST_BAD_EPB;
				nal_state.unit_failed = 1'b1;
			end else begin
				r.payload_byte = b.data_byte;
				r.byte_valid = 1'b1;
				nal_state.zero_run = (b.data_byte == NUL_BYTE) ? 2'd1 : 2'd0;
			end
		end else if (nal_state.zero_run >= ZERO_LIMIT && b.data_byte < PREVENTION_BYTE) begin
			r.status = ST_FORBIDDEN;
			nal_state.unit_failed = 1'b1;
		end else if (nal_state.zero_run >= ZERO_LIMIT && b.data_byte == PREVENTION_BYTE) begin
			nal_state.zero_run = 2'd0;
			nal_state.after_prevention = !b.unit_last;
		end else begin
			r.payload_byte = b.data_byte;
			r.byte_valid = 1'b1;
			if (b.data_byte == NUL_BYTE) begin
				if (nal_state.zero_run < ZERO_LIMIT)
					nal_state.zero_run = nal_state.zero_run + 2'd1;
			end else begin
				nal_state.zero_run = 2'd0;
			end
		end
		if (b.unit_last)
			nal_state = '{1'b1, 2'd0, 1'b0, 1'b0};
		return r;
	endfunction

	// called at a falling edge; returns at a falling edge with in_valid still high
	task automatic send_beat(input in_beat_t b, input logic given, input out_beat_t want);
		out_beat_t predicted;
		while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 86) ||
		       (idle_mode == IDLE_BOTH && $urandom_range(99) < 8)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = strip_epb(b);
		rbsp_expected.push_back(given ? want : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (rbsp_expected.size() != 0);
	endtask

	// mostly well-formed units: prevention bytes after zero pairs, small bytes after them
	task automatic send_random_unit();
		int        len;
		int        idx;
		int        zeros;
		bit        noisy;
		bit        epb;
		logic [7:0] data;
		int        roll;
		len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
		noisy = $urandom_range(99) < 15;
		zeros = 0;
		epb = 1'b0;
		for (idx = 0; idx < len; idx++) begin
			roll = $urandom_range(99);
			if (idx == 0)
				data = 8'($urandom);
			else if (noisy)
				data = (roll < 35) ? NUL_BYTE : 8'($urandom);
			else if (epb)
				data = (roll < 85) ? 8'($urandom_range(3)) : 8'($urandom);
			else if (zeros >= 2)
				data = (roll < 80) ? PREVENTION_BYTE :
				       (roll < 92) ? 8'($urandom_range(2)) : 8'($urandom);
			else
				data = (roll < 45) ? NUL_BYTE : (roll < 52) ? PREVENTION_BYTE : 8'($urandom);
			if (idx != 0) begin
				if (epb) begin
					epb = 1'b0;
					zeros = (data == NUL_BYTE) ? 1 : 0;
				end else if (zeros >= 2 && data == PREVENTION_BYTE) begin
					epb = 1'b1;
					zeros = 0;
				end else begin
					zeros = (data != NUL_BYTE) ? 0 : (zeros < 2) ? zeros + 1 : 2;
				end
			end
			send_beat('{data, idx == len - 1}, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK});
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		int hold_left;
		bit hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_left = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (idle_mode == IDLE_RECEIVER) begin
				out_ready <= $urandom_range(99) >= 86;
			end else if (idle_mode == IDLE_BOTH) begin
				out_ready <= $urandom_range(99) >= 8;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rbsp_expected.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, out_data);
				mismatches++;
			end else begin
				want = rbsp_expected.pop_front();
				if (out_data.payload_byte !== want.payload_byte) begin
					$display("%0t: payload_byte expected %h got %h", $time,
						want.payload_byte, out_data.payload_byte);
					mismatches++;
				end
				if (out_data.byte_valid !== want.byte_valid) begin
					$display("%0t: byte_valid expected %b got %b", $time,
						want.byte_valid, out_data.byte_valid);
					mismatches++;
				end
				if (out_data.unit_end !== want.unit_end) begin
					$display("%0t: unit_end expected %b got %b", $time,
						want.unit_end, out_data.unit_end);
					mismatches++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, out_data.status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int row;
		int phase;
		beats_sent = 0;
		hold_req = 1'b0;
		idle_mode = IDLE_NONE;
		nal_state = '{1'b1, 2'd0, 1'b0, 1'b0};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < DIR_ROWS; row++)
			send_beat(dir_rows[row].beat, dir_rows[row].given, dir_rows[row].want);
		drain();

		for (phase = 0; phase < 4; phase++) begin
			idle_mode = idle_mode_t'(phase);
			beats_sent = 0;
			while (beats_sent < PHASE_BEATS)
				send_random_unit();
			drain();
		end

		// long receiver hold-off while beats keep coming
		idle_mode = IDLE_NONE;
		hold_req = 1'b1;
		beats_sent = 0;
		while (beats_sent < PHASE_BEATS)
			send_random_unit();
		drain();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && rbsp_expected.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/epr_pkg.sv
src/epr_core.sv
src/emulation_prevention_remover_top.sv
test/testbench.sv
